### sv/gnc_pkg.sv
// ----------------------------------------------------------------------------
// Eight-neighbor count package
// Shared types and constants for the mark grid neighbor counter.
// ----------------------------------------------------------------------------
package gnc_pkg;

    localparam int CFG_W      = 6;
    localparam int COORD_W    = 5;
    localparam int COUNT_W    = 4;
    localparam int NBR_COUNT  = 8;
    localparam int NBR_IDX_W  = 3;

    // Item kinds.
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // Configuration register indexes.
    localparam logic CFG_ROW_COUNT = 1'b0;
    localparam logic CFG_COL_COUNT = 1'b1;

    localparam logic [CFG_W-1:0] ROW_COUNT_RST = 6'd32;
    localparam logic [CFG_W-1:0] COL_COUNT_RST = 6'd32;

    // Neighbor offsets, biased by one so that they stay unsigned.
    localparam logic [1:0] DR_P1 [NBR_COUNT] =
        '{2'd0, 2'd0, 2'd1, 2'd2, 2'd2, 2'd2, 2'd1, 2'd0};
    localparam logic [1:0] DC_P1 [NBR_COUNT] =
        '{2'd1, 2'd2, 2'd2, 2'd2, 2'd1, 2'd0, 2'd0, 2'd0};

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_READ  = 4'b0100,
        S_FLUSH = 4'b1000
    } t_state;

    typedef struct packed {
        logic                 clear_step;
        logic                 write_cell;
        logic                 load_query;
        logic                 read_step;
        logic                 finish;
        logic                 out_oor;
        logic [NBR_IDX_W-1:0] nbr_idx;
    } t_dp_cmd;

    typedef struct packed {
        logic clear_done;
        logic query_inside;
    } t_dp_stat;

endpackage

### sv/grid_eight_neighbor_count.sv
// A query inside the grid strobes its result after eight neighbor reads and a flush
// state; a query outside the grid strobes in the cycle after the beat is taken. One
// write per cycle while busy is low; a query holds busy through eight reads of the
// single-port mark memory. Reset: row and column counts return to 32 and busy stays
// high while all MAX_ROWS*MAX_COLS cells clear. The receiver cannot stall results.
// ----------------------------------------------------------------------------
// Eight-neighbor mark counter
// Stores a bit grid of marks and counts the marked neighbors of a cell.
// ----------------------------------------------------------------------------
module grid_eight_neighbor_count
    import gnc_pkg::*;
#(
    parameter int MAX_ROWS = 32,
    parameter int MAX_COLS = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_idx,
    input  logic [CFG_W-1:0]   i_cfg_data,
    input  logic               start,
    output logic               busy,
    input  logic               i_kind,
    input  logic [COORD_W-1:0] i_row,
    input  logic [COORD_W-1:0] i_col,
    input  logic               i_mark,
    output logic               o_result_valid,
    output logic [COUNT_W-1:0] o_count,
    output logic               o_in_range
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    gnc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_kind  (i_kind),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    gnc_dpath #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_row          (i_row),
        .i_col          (i_col),
        .i_mark         (i_mark),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .o_result_valid (o_result_valid),
        .o_count        (o_count),
        .o_in_range     (o_in_range)
    );

    a_oor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && !o_in_range) |-> (o_count == '0))
        else $error("out-of-range query returned a nonzero count");

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> (o_count <= COUNT_W'(NBR_COUNT)))
        else $error("neighbor count above eight");

    a_write_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_kind == KIND_WRITE)) |=> !o_result_valid)
        else $error("write beat produced a result");

    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.load_query) |=> (busy && !o_result_valid))
        else $error("query in range did not hold busy");

endmodule

### sv/gnc_ctrl.sv
// ----------------------------------------------------------------------------
// Eight-neighbor count controller
// Sequences the clearing pass, cell writes and the eight neighbor reads.
// ----------------------------------------------------------------------------
module gnc_ctrl
    import gnc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  logic     i_kind,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd,
    output logic     o_busy
);

    t_state               r_state, n_state;
    logic [NBR_IDX_W-1:0] r_k, n_k;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
        end
    end

    always_comb begin
        n_state       = r_state;
        n_k           = r_k;
        o_cmd         = '0;
        o_cmd.nbr_idx = r_k;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear_step = 1'b1;
                if (i_stat.clear_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    if (i_kind == KIND_QUERY) begin
                        if (i_stat.query_inside) begin
                            o_cmd.load_query = 1'b1;
                            n_k              = '0;
                            n_state          = S_READ;
                        end else begin
                            o_cmd.out_oor = 1'b1;
                        end
                    end else begin
                        o_cmd.write_cell = 1'b1;
                    end
                end
            end
            S_READ: begin
                o_cmd.read_step = 1'b1;
                n_k             = r_k + 1'b1;
                if (r_k == NBR_IDX_W'(NBR_COUNT - 1)) begin
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: begin
                o_cmd.finish = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

### sv/gnc_dpath.sv
// ----------------------------------------------------------------------------
// Eight-neighbor count datapath
// Holds the configuration, the single-port mark memory and the count logic.
// ----------------------------------------------------------------------------
module gnc_dpath
    import gnc_pkg::*;
#(
    parameter int MAX_ROWS = 32,
    parameter int MAX_COLS = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_idx,
    input  logic [CFG_W-1:0]   i_cfg_data,
    input  logic [COORD_W-1:0] i_row,
    input  logic [COORD_W-1:0] i_col,
    input  logic               i_mark,
    input  t_dp_cmd            i_cmd,
    output t_dp_stat           o_stat,
    output logic               o_result_valid,
    output logic [COUNT_W-1:0] o_count,
    output logic               o_in_range
);

    localparam int RW   = $clog2(MAX_ROWS);
    localparam int CW   = $clog2(MAX_COLS);
    localparam int UR_W = ($clog2(MAX_ROWS + 1) > CFG_W) ? $clog2(MAX_ROWS + 1) : CFG_W;
    localparam int UC_W = ($clog2(MAX_COLS + 1) > CFG_W) ? $clog2(MAX_COLS + 1) : CFG_W;

    logic [CFG_W-1:0]   r_row_count, r_col_count;
    logic [COORD_W-1:0] r_row, r_col;
    logic [RW-1:0]      r_clr_r;
    logic [CW-1:0]      r_clr_c;
    logic               r_grid [MAX_ROWS][MAX_COLS];
    logic               r_rd_data;
    logic               r_rd_valid;
    logic [COUNT_W-1:0] r_cnt;
    logic [COUNT_W-1:0] n_cnt;
    logic               r_out_valid;
    logic [COUNT_W-1:0] r_out_count;
    logic               r_out_in_range;

    logic [UR_W-1:0]    used_rows;
    logic [UC_W-1:0]    used_cols;
    logic               in_inside;
    logic [CFG_W-1:0]   rn_p1, cn_p1;
    logic               nbr_inside;
    logic [RW-1:0]      nbr_r, mem_r;
    logic [CW-1:0]      nbr_c, mem_c;
    logic               mem_we, mem_wd;
    logic               clr_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count <= ROW_COUNT_RST;
            r_col_count <= COL_COUNT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ROW_COUNT: r_row_count <= i_cfg_data;
                CFG_COL_COUNT: r_col_count <= i_cfg_data;
                default:       r_row_count <= r_row_count;
            endcase
        end
    end

    // A register above the grid size acts as the grid size.
    assign used_rows = (UR_W'(r_row_count) > UR_W'(MAX_ROWS)) ? UR_W'(MAX_ROWS)
                                                                : UR_W'(r_row_count);
    assign used_cols = (UC_W'(r_col_count) > UC_W'(MAX_COLS)) ? UC_W'(MAX_COLS)
                                                                : UC_W'(r_col_count);

    assign in_inside = (UR_W'(i_row) < used_rows) && (UC_W'(i_col) < used_cols);

    // Neighbor coordinates plus one: zero means the row above or the column left of the grid.
    assign rn_p1 = CFG_W'(r_row) + CFG_W'(DR_P1[i_cmd.nbr_idx]);
    assign cn_p1 = CFG_W'(r_col) + CFG_W'(DC_P1[i_cmd.nbr_idx]);

    assign nbr_inside = (rn_p1 != '0) && (UR_W'(rn_p1) <= used_rows)
                     && (cn_p1 != '0) && (UC_W'(cn_p1) <= used_cols);
    assign nbr_r = nbr_inside ? RW'(rn_p1 - 1'b1) : '0;
    assign nbr_c = nbr_inside ? CW'(cn_p1 - 1'b1) : '0;

    assign clr_last = (r_clr_r == RW'(MAX_ROWS - 1)) && (r_clr_c == CW'(MAX_COLS - 1));

    always_comb begin
        if (i_cmd.clear_step) begin
            mem_r  = r_clr_r;
            mem_c  = r_clr_c;
            mem_we = 1'b1;
            mem_wd = 1'b0;
        end else if (i_cmd.write_cell) begin
            mem_r  = in_inside ? RW'(i_row) : '0;
            mem_c  = in_inside ? CW'(i_col) : '0;
            mem_we = in_inside;
            mem_wd = i_mark;
        end else begin
            mem_r  = nbr_r;
            mem_c  = nbr_c;
            mem_we = 1'b0;
            mem_wd = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_grid[mem_r][mem_c] <= mem_wd;
        end
        r_rd_data <= r_grid[mem_r][mem_c];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_r <= '0;
            r_clr_c <= '0;
        end else if (i_cmd.clear_step) begin
            if (r_clr_c == CW'(MAX_COLS - 1)) begin
                r_clr_c <= '0;
                r_clr_r <= clr_last ? '0 : r_clr_r + 1'b1;
            end else begin
                r_clr_c <= r_clr_c + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_query) begin
            r_row <= i_row;
            r_col <= i_col;
        end
    end

    // Read data is registered after its address, so the add trails the read.
    assign n_cnt = r_cnt + COUNT_W'(r_rd_valid & r_rd_data);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_valid <= 1'b0;
            r_cnt      <= '0;
        end else if (i_cmd.load_query) begin
            r_rd_valid <= 1'b0;
            r_cnt      <= '0;
        end else if (i_cmd.read_step) begin
            r_rd_valid <= nbr_inside;
            r_cnt      <= n_cnt;
        end else begin
            r_rd_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= i_cmd.finish | i_cmd.out_oor;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out_count    <= n_cnt;
            r_out_in_range <= 1'b1;
        end else if (i_cmd.out_oor) begin
            r_out_count    <= '0;
            r_out_in_range <= 1'b0;
        end
    end

    assign o_stat.clear_done   = clr_last;
    assign o_stat.query_inside = in_inside;
    assign o_result_valid      = r_out_valid;
    assign o_count             = r_out_count;
    assign o_in_range          = r_out_in_range;

endmodule
